### rtl/core/pair_keyed_id_registry_top_assert.svh
// assertion macros for the pair-keyed id registry checker
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef PAIR_KEYED_ID_REGISTRY_TOP_ASSERT_SVH
`define PAIR_KEYED_ID_REGISTRY_TOP_ASSERT_SVH

// same-cycle implication, disabled in reset
`define PKIR_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define PKIR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/pkir_pkg.sv
// shared types and constants of the pair-keyed id registry
// no dependencies
package pkir_pkg;

  localparam int REQ_W   = 2;
  localparam int FIELD_W = 16;
  localparam int KEY_W   = 1 + 2 * FIELD_W;

  localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd0;
  localparam logic [REQ_W-1:0] REQ_GET    = 2'd1;
  localparam logic [REQ_W-1:0] REQ_FORCE  = 2'd2;

  // request token that walks the cell row
  typedef struct packed {
    logic             valid;
    logic [REQ_W-1:0] req;
    logic [KEY_W-1:0] key;
    logic             done;
    logic             found;
    logic             inserted;
  } tok_t;

  function automatic logic is_insert(input logic [REQ_W-1:0] req);
    return (req == REQ_GET) || (req == REQ_FORCE);
  endfunction

endpackage

### rtl/core/pkir_cell.sv
// one storage cell of the registry row: key, id and a token stage
// depends on pkir_pkg
module pkir_cell #(
  parameter int ID_BITS = 16,
  parameter int CNT_W   = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pkir_pkg::tok_t      tok_i,
  input  logic [ID_BITS-1:0]  id_i,
  input  logic [CNT_W-1:0]    rem_i,
  output pkir_pkg::tok_t      tok_o,
  output logic [ID_BITS-1:0]  id_o,
  output logic [CNT_W-1:0]    rem_o
);
  import pkir_pkg::*;

  logic [KEY_W-1:0]   key_q;
  logic [ID_BITS-1:0] val_q;
  tok_t               tok_q, tok_d;
  logic [ID_BITS-1:0] id_q, id_d;
  logic [CNT_W-1:0]   rem_q, rem_d;
  logic               key_we, val_we;
  logic               occupied;

  // cells below the fill count are occupied
  assign occupied = (rem_i != '0);

  always_comb begin
    tok_d  = tok_i;
    id_d   = id_i;
    rem_d  = rem_i;
    key_we = 1'b0;
    val_we = 1'b0;
    if (tok_i.valid && !tok_i.done) begin
      if (occupied) begin
        rem_d = rem_i - 1'b1;
        if (key_q == tok_i.key) begin
          tok_d.done  = 1'b1;
          tok_d.found = 1'b1;
          if (tok_i.req == REQ_FORCE) begin
            tok_d.inserted = 1'b1;
            val_we         = 1'b1;
          end else begin
            id_d = val_q;
          end
        end
      end else begin
        // first free cell
        tok_d.done = 1'b1;
        if (is_insert(tok_i.req)) begin
          tok_d.inserted = 1'b1;
          key_we         = 1'b1;
          val_we         = 1'b1;
        end else begin
          id_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q  <= id_d;
    rem_q <= rem_d;
    if (key_we) begin
      key_q <= tok_i.key;
    end
    if (val_we) begin
      val_q <= id_i;
    end
  end

  assign tok_o = tok_q;
  assign id_o  = id_q;
  assign rem_o = rem_q;

endmodule

### rtl/core/pair_keyed_id_registry_top.sv
// pair-keyed id registry: controller, counters and the row of storage cells
// depends on pkir_pkg and pkir_cell
//
// input channel (in_valid_i / in_stall_o) takes one request beat: req_type,
// table_sel, src_id, dst_id. output channel (out_valid_o / out_stall_i) returns
// one result beat per request, in order.
// cfg channel (cfg_valid_i / cfg_ready_o) writes first_node_id; the write empties
// both tables at once (fill count to zero), loads the node counter and zeroes the
// link counter. cfg_ready_o is low while a request walks the row, and a pending
// cfg beat holds in_stall_o high so the two never land on the same edge.
// row walk: a request token walks the cell row one cell per cycle, and its result
// is registered at the row exit; the next beat is taken only once the previous
// token has left the row. the row length sets the walk time of each request.
// reset: tables empty, both counters zero, no beat pending.
// stall: a result held by out_stall_i stays on the output register; the next
// request still runs and its result waits in a spare register. while that spare
// is full, in_stall_o stays high.
module pair_keyed_id_registry_top #(
  parameter int ENTRIES = 512,
  parameter int ID_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [pkir_pkg::REQ_W-1:0]    req_type_i,
  input  logic                          table_sel_i,
  input  logic [pkir_pkg::FIELD_W-1:0]  src_id_i,
  input  logic [pkir_pkg::FIELD_W-1:0]  dst_id_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [pkir_pkg::FIELD_W-1:0]  assigned_id_o,
  output logic                          found_o,
  output logic                          inserted_o,
  output logic                          table_full_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [pkir_pkg::FIELD_W-1:0]  cfg_data_i
);
  import pkir_pkg::*;

  localparam int CNT_W = $clog2(ENTRIES + 1);

  typedef struct packed {
    logic [FIELD_W-1:0] id;
    logic               found;
    logic               inserted;
    logic               full;
  } res_t;

  // token row: index g feeds cell g, index ENTRIES is the row exit
  tok_t               tok  [ENTRIES+1];
  logic [ID_BITS-1:0] tid  [ENTRIES+1];
  logic [CNT_W-1:0]   trem [ENTRIES+1];

  logic               walk_q;       // a request is in the row
  logic               out_valid_q;
  logic               pend_vld_q;   // spare result register full
  res_t               out_res_q, pend_res_q, ex_res;
  logic [ID_BITS-1:0] node_q, link_q;
  logic [CNT_W-1:0]   used_q;       // fill count, occupied cells form a prefix

  logic in_acc, cfg_acc, out_take, ex_vld;

  assign in_stall_o  = walk_q | pend_vld_q | cfg_valid_i;
  assign cfg_ready_o = ~walk_q;
  assign in_acc      = in_valid_i & ~in_stall_o;
  assign cfg_acc     = cfg_valid_i & cfg_ready_o;
  assign out_take    = out_valid_q & ~out_stall_i;
  assign ex_vld      = tok[ENTRIES].valid;

  // inject the request at the head of the row with the current counter
  assign tok[0]  = {in_acc, req_type_i, table_sel_i, src_id_i, dst_id_i, 3'b000};
  assign tid[0]  = table_sel_i ? link_q : node_q;
  assign trem[0] = used_q;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    pkir_cell #(
      .ID_BITS(ID_BITS),
      .CNT_W  (CNT_W)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .tok_i (tok[g]),
      .id_i  (tid[g]),
      .rem_i (trem[g]),
      .tok_o (tok[g+1]),
      .id_o  (tid[g+1]),
      .rem_o (trem[g+1])
    );
  end

  // result at the row exit; an unresolved insert found every cell occupied
  always_comb begin
    ex_res.id       = tok[ENTRIES].done ? FIELD_W'(tid[ENTRIES]) : '0;
    ex_res.found    = tok[ENTRIES].found;
    ex_res.inserted = tok[ENTRIES].inserted;
    ex_res.full     = ~tok[ENTRIES].done & is_insert(tok[ENTRIES].req)
                      & (trem[ENTRIES] == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_q      <= 1'b0;
      out_valid_q <= 1'b0;
      pend_vld_q  <= 1'b0;
      node_q      <= '0;
      link_q      <= '0;
      used_q      <= '0;
    end else begin
      if (in_acc) begin
        walk_q <= 1'b1;
      end else if (ex_vld) begin
        walk_q <= 1'b0;
      end

      // output register with one spare behind it
      if (ex_vld) begin
        if (!out_valid_q || out_take) begin
          out_valid_q <= 1'b1;
        end else begin
          pend_vld_q <= 1'b1;
        end
      end else if (out_take) begin
        out_valid_q <= pend_vld_q;
        pend_vld_q  <= 1'b0;
      end

      // counters advance only when an id was stored
      if (ex_vld && tok[ENTRIES].inserted) begin
        if (tok[ENTRIES].key[KEY_W-1]) begin
          link_q <= link_q + 1'b1;
        end else begin
          node_q <= node_q + 1'b1;
        end
        if (!tok[ENTRIES].found) begin
          used_q <= used_q + 1'b1;
        end
      end

      if (cfg_acc) begin
        node_q <= ID_BITS'(cfg_data_i);
        link_q <= '0;
        used_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ex_vld) begin
      if (!out_valid_q || out_take) begin
        out_res_q <= ex_res;
      end else begin
        pend_res_q <= ex_res;
      end
    end else if (out_take && pend_vld_q) begin
      out_res_q <= pend_res_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign assigned_id_o = out_res_q.id;
  assign found_o       = out_res_q.found;
  assign inserted_o    = out_res_q.inserted;
  assign table_full_o  = out_res_q.full;

endmodule

### rtl/core/pkir_checker.sv
// port-level checks of the pair-keyed id registry, bound to the top level
// depends on pair_keyed_id_registry_top_assert.svh
`include "pair_keyed_id_registry_top_assert.svh"

module pkir_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [15:0] assigned_id_o,
  input logic        found_o,
  input logic        inserted_o,
  input logic        table_full_o,
  input logic        cfg_ready_o
);

  // stalled result beat holds
  `PKIR_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
    out_valid_o && $stable(assigned_id_o) && $stable(found_o) && $stable(inserted_o)
    && $stable(table_full_o), "stalled result beat changed")

  // one request in flight: an accepted beat closes the input and cfg channels
  `PKIR_ASSERT_NEXT(a_one_at_a_time, in_valid_i && !in_stall_o,
    in_stall_o && !cfg_ready_o, "request taken while another is in flight")

  // refused insert reports nothing stored and a zero id
  `PKIR_ASSERT_IMPL(a_full_result, out_valid_o && table_full_o,
    !inserted_o && !found_o && (assigned_id_o == 16'd0), "inconsistent full result")

  // a stored id never comes with a refusal
  `PKIR_ASSERT_IMPL(a_ins_flags, out_valid_o && inserted_o,
    !table_full_o, "insert and full flagged together")

endmodule

bind pair_keyed_id_registry_top pkir_checker u_pkir_checker (.*);
